// ===== hw/rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    // Field widths
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int ID_W    = 7;
    localparam int TIME_W  = 23;

    // Default job table depth
    localparam int MAX_PROCESSES_DEF = 16;

    // One job table entry
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] remain;
    } t_entry;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_SETTLE,
        ST_CALC,
        ST_COMMIT,
        ST_FINISH,
        ST_RESULT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // store accepted job request
        logic start;    // clear scan accumulators
        logic scan_rd;  // read next table entry
        logic calc;     // pick run length or jump time
        logic commit;   // advance time, write back remaining
        logic finish;   // load completion record
        logic clear;    // end of run, drop the set
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic run_req;   // accepted job closes the set
        logic scan_last; // last table entry being read
        logic found;     // a ready job was found in the scan
        logic finished;  // selected job completes on commit
        logic all_done;  // every job of the set has completed
        logic out_taken; // completion record taken downstream
    } t_stat;

endpackage

// ===== hw/rtl/pps_if.sv =====
// ----------------------------------------------------------------------------
// pps_if
// Valid/ready channels for job requests and completion records.
// ----------------------------------------------------------------------------
interface pps_job_if;
    logic                          valid;
    logic                          ready;
    logic [pps_pkg::ARR_W-1:0]     arr_tick;
    logic [pps_pkg::BURST_W-1:0]   burst_units;
    logic [pps_pkg::PRIO_W-1:0]    priority_req;
    logic                          last_job;

    modport source (output valid, arr_tick, burst_units, priority_req, last_job,
                    input ready);
    modport sink   (input valid, arr_tick, burst_units, priority_req, last_job,
                    output ready);
endinterface

interface pps_res_if;
    logic                          valid;
    logic                          ready;
    logic [pps_pkg::ID_W-1:0]      job_id;
    logic [pps_pkg::TIME_W-1:0]    turnaround;
    logic [pps_pkg::TIME_W-1:0]    waiting;
    logic                          last_result;

    modport source (output valid, job_id, turnaround, waiting, last_result,
                    input ready);
    modport sink   (input valid, job_id, turnaround, waiting, last_result,
                    output ready);
endinterface

// ===== hw/rtl/pps_ctrl.sv =====
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: loads jobs, then steps scan / calc / commit per scheduling event.
// ----------------------------------------------------------------------------
module pps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  pps_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output pps_pkg::t_cmd  o_cmd
);

    pps_pkg::t_state r_state;
    pps_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            pps_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.run_req) begin
                        n_state = pps_pkg::ST_START;
                    end
                end
            end
            pps_pkg::ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = pps_pkg::ST_SCAN;
            end
            pps_pkg::ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = pps_pkg::ST_SETTLE;
                end
            end
            pps_pkg::ST_SETTLE: begin
                n_state = pps_pkg::ST_CALC;
            end
            pps_pkg::ST_CALC: begin
                o_cmd.calc = 1'b1;
                // no ready job: time jumps, rescan
                n_state = i_stat.found ? pps_pkg::ST_COMMIT : pps_pkg::ST_START;
            end
            pps_pkg::ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = i_stat.finished ? pps_pkg::ST_FINISH : pps_pkg::ST_START;
            end
            pps_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = pps_pkg::ST_RESULT;
            end
            pps_pkg::ST_RESULT: begin
                if (i_stat.out_taken) begin
                    if (i_stat.all_done) begin
                        o_cmd.clear = 1'b1;
                        n_state     = pps_pkg::ST_IDLE;
                    end else begin
                        n_state = pps_pkg::ST_START;
                    end
                end
            end
            default: begin
                n_state = pps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pps_dpath.sv =====
// ----------------------------------------------------------------------------
// pps_dpath
// Job table memory, scan accumulators, time keeping and result register.
// ----------------------------------------------------------------------------
module pps_dpath #(
    parameter int MAX_PROCESSES = pps_pkg::MAX_PROCESSES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pps_pkg::t_cmd               i_cmd,
    output pps_pkg::t_stat              o_stat,
    input  logic [pps_pkg::ARR_W-1:0]   i_arr_tick,
    input  logic [pps_pkg::BURST_W-1:0] i_burst_units,
    input  logic [pps_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic                        i_last_job,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [pps_pkg::ID_W-1:0]    o_job_id,
    output logic [pps_pkg::TIME_W-1:0]  o_turnaround,
    output logic [pps_pkg::TIME_W-1:0]  o_waiting,
    output logic                        o_last_result
);

    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
    localparam int ARR_W   = pps_pkg::ARR_W;
    localparam int BURST_W = pps_pkg::BURST_W;
    localparam int PRIO_W  = pps_pkg::PRIO_W;
    localparam int TIME_W  = pps_pkg::TIME_W;
    localparam int ID_W    = pps_pkg::ID_W;

    // Job table
    pps_pkg::t_entry r_mem [MAX_PROCESSES];

    logic [CNT_W-1:0]   r_job_cnt;
    logic [CNT_W-1:0]   r_done;
    logic [TIME_W-1:0]  r_now;

    logic [IDX_W-1:0]   r_scan_idx;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    pps_pkg::t_entry    r_rd_data;

    // Best ready job of the scan
    logic               r_found;
    logic [IDX_W-1:0]   r_bidx;
    logic [ARR_W-1:0]   r_barr;
    logic [BURST_W-1:0] r_bburst;
    logic [PRIO_W-1:0]  r_bprio;
    logic [BURST_W-1:0] r_brem;

    // Earliest future arrival of an unfinished job
    logic               r_nfound;
    logic [ARR_W-1:0]   r_next;

    logic [BURST_W-1:0] r_len;
    logic               r_out_vld;

    logic [BURST_W-1:0] w_burst;
    logic [IDX_W-1:0]   w_slot;
    pps_pkg::t_entry    w_load_entry;
    logic               w_e_live;
    logic               w_e_ready;
    logic               w_e_future;
    logic               w_e_better;
    logic [BURST_W-1:0] w_gap;
    logic [BURST_W-1:0] w_len;
    logic [TIME_W-1:0]  w_turn;
    logic               w_out_taken;

    // Load entry, zero burst runs one unit
    always_comb begin
        w_burst = (i_burst_units == '0) ? BURST_W'(1) : i_burst_units;
        w_slot  = r_job_cnt[IDX_W-1:0];
        w_load_entry.arrival = i_arr_tick;
        w_load_entry.burst   = w_burst;
        w_load_entry.prio    = i_priority_req;
        w_load_entry.remain  = w_burst;
    end

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[w_slot] <= w_load_entry;
        end else if (i_cmd.commit) begin
            r_mem[r_bidx] <= '{arrival: r_barr, burst: r_bburst, prio: r_bprio,
                               remain: r_brem - r_len};
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_mem[r_scan_idx];
            r_rd_idx  <= r_scan_idx;
        end
    end

    // Entry classification during scan
    always_comb begin
        w_e_live   = (r_rd_data.remain != '0);
        w_e_ready  = w_e_live && (TIME_W'(r_rd_data.arrival) <= r_now);
        w_e_future = w_e_live && !w_e_ready;
        w_e_better = !r_found || (r_rd_data.prio < r_bprio) ||
                     ((r_rd_data.prio == r_bprio) && (r_rd_data.arrival < r_barr));
    end

    // Run length: up to the next arrival or to completion
    always_comb begin
        w_gap = r_next - r_now[ARR_W-1:0];
        w_len = (r_nfound && (w_gap < r_brem)) ? w_gap : r_brem;
    end

    assign w_turn      = r_now - TIME_W'(r_barr);
    assign w_out_taken = r_out_vld && i_out_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_cnt  <= '0;
            r_done     <= '0;
            r_now      <= '0;
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_nfound   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_job_cnt <= r_job_cnt + CNT_W'(1);
            end
            if (i_cmd.start) begin
                r_scan_idx <= '0;
                r_found    <= 1'b0;
                r_nfound   <= 1'b0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan_idx <= r_scan_idx + IDX_W'(1);
                end
                if (r_rd_vld && w_e_ready && w_e_better) begin
                    r_found <= 1'b1;
                end
                if (r_rd_vld && w_e_future && (!r_nfound || (r_rd_data.arrival < r_next))) begin
                    r_nfound <= 1'b1;
                end
            end
            if (i_cmd.calc && !r_found) begin
                r_now <= TIME_W'(r_next);
            end
            if (i_cmd.commit) begin
                r_now <= r_now + TIME_W'(r_len);
            end
            if (i_cmd.finish) begin
                r_done    <= r_done + CNT_W'(1);
                r_out_vld <= 1'b1;
            end else if (w_out_taken) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_job_cnt <= '0;
                r_done    <= '0;
                r_now     <= '0;
            end
        end
    end

    // Payload registers of the scan and result
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && w_e_ready && w_e_better) begin
            r_bidx   <= r_rd_idx;
            r_barr   <= r_rd_data.arrival;
            r_bburst <= r_rd_data.burst;
            r_bprio  <= r_rd_data.prio;
            r_brem   <= r_rd_data.remain;
        end
        if (r_rd_vld && w_e_future && (!r_nfound || (r_rd_data.arrival < r_next))) begin
            r_next <= r_rd_data.arrival;
        end
        if (i_cmd.calc) begin
            r_len <= w_len;
        end
        if (i_cmd.finish) begin
            o_job_id      <= ID_W'(r_bidx) + ID_W'(1);
            o_turnaround  <= w_turn;
            o_waiting     <= w_turn - TIME_W'(r_bburst);
            o_last_result <= ((r_done + CNT_W'(1)) == r_job_cnt);
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.run_req   = i_last_job || (r_job_cnt == CNT_W'(MAX_PROCESSES - 1));
        o_stat.scan_last = ((CNT_W'(r_scan_idx) + CNT_W'(1)) == r_job_cnt);
        o_stat.found     = r_found;
        o_stat.finished  = (r_brem == r_len);
        o_stat.all_done  = (r_done == r_job_cnt);
        o_stat.out_taken = w_out_taken;
    end

    assign o_out_valid = r_out_vld;

`ifndef ASSERT_OFF
    a_done_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done <= r_job_cnt)
        else $error("completions exceed loaded jobs");

    a_cnt_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_cnt <= CNT_W'(MAX_PROCESSES))
        else $error("job count beyond table depth");

    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_done == '0) && !r_out_vld && (r_now == '0))
        else $error("job loaded while a run is open");

    a_result_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_vld && (r_done != '0))
        else $error("completion record without a counted completion");
`endif

endmodule

// ===== hw/rtl/preemptive_priority_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Loads a job set, then runs preemptive priority scheduling and emits one
// completion record per job in completion order.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  i_job    in   valid/ready        arr_tick, burst_units, priority_req,
//                                   last_job
//  o_res    out  valid/ready        job_id, turnaround, waiting, last_result
//
//  A job request is taken as soon as it is valid while loading; the run
//  starts after the request marked last_job or the one that fills the table.
//  Each scheduling event walks the table through one memory read port, then
//  settles, picks a run length or an idle time jump and, for a run, commits;
//  a completion then loads its record and waits for the output handshake.
//  Events are completions, preemptions by an arrival, and idle time jumps.
//  i_job.ready stays low for the whole run; a stalled o_res holds the run.
//  Reset is synchronous, active low; the table contents are not cleared.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_core #(
    parameter int MAX_PROCESSES = pps_pkg::MAX_PROCESSES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pps_job_if.sink   i_job,
    pps_res_if.source o_res
);

    pps_pkg::t_cmd  w_cmd;
    pps_pkg::t_stat w_stat;

    // Sequencer
    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_job.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_job.ready),
        .o_cmd      (w_cmd)
    );

    // Datapath
    pps_dpath #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_arr_tick     (i_job.arr_tick),
        .i_burst_units  (i_job.burst_units),
        .i_priority_req (i_job.priority_req),
        .i_last_job     (i_job.last_job),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_job_id       (o_res.job_id),
        .o_turnaround   (o_res.turnaround),
        .o_waiting      (o_res.waiting),
        .o_last_result  (o_res.last_result)
    );

endmodule

// ===== tb/pps_checker.sv =====
// ----------------------------------------------------------------------------
// pps_checker
// Watches the job and completion channels of the scheduler core. Every
// accepted job request is stored in a local job table. When a set closes,
// the checker runs its own preemptive priority schedule and queues the
// completion records it predicts. Each accepted record is compared, field by
// field, with the oldest one in that queue.
// ----------------------------------------------------------------------------
module pps_checker #(
    parameter int MAX_JOBS = pps_pkg::MAX_PROCESSES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pps_job_if   i_job,
    pps_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import pps_pkg::*;

    // Predicted completion record
    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              last_result;
    } t_done_rec;

    // Local job table of the set being loaded
    logic [ARR_W-1:0]   job_arr    [MAX_JOBS];
    logic [BURST_W-1:0] job_burst  [MAX_JOBS];
    logic [PRIO_W-1:0]  job_prio   [MAX_JOBS];
    logic [BURST_W-1:0] job_remain [MAX_JOBS];
    int                 jobs_loaded;

    t_done_rec          done_q[$];
    int                 fail_cnt;
    int                 rec_cnt;

    initial begin
        jobs_loaded  = 0;
        fail_cnt     = 0;
        rec_cnt      = 0;
    end

    // One line per failure, and count it
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch: record %0d %s: got %0d, expected %0d",
                 rec_cnt, what, got, want);
        fail_cnt++;
    endtask

    // Schedule the loaded set from time zero, queue records in completion order
    task automatic schedule_set();
        int unsigned now_t;
        int unsigned done_n;
        int unsigned run_len;
        int unsigned gap;
        int unsigned next_arr;
        int          best;
        t_done_rec   rec;
        now_t  = 0;
        done_n = 0;
        while (done_n < jobs_loaded) begin
            // Pick the ready job: lowest priority, then earliest arrival,
            // then earliest load position
            best = -1;
            for (int k = 0; k < jobs_loaded; k++) begin
                if (job_remain[k] != 0 && job_arr[k] <= now_t) begin
                    if (best < 0 || job_prio[k] < job_prio[best] ||
                        (job_prio[k] == job_prio[best] && job_arr[k] < job_arr[best]))
                        best = k;
                end
            end
            if (best < 0) begin
                // Nothing ready: jump to the next arrival
                next_arr = 32'hFFFF_FFFF;
                for (int k = 0; k < jobs_loaded; k++)
                    if (job_remain[k] != 0 && job_arr[k] < next_arr)
                        next_arr = 32'(job_arr[k]);
                now_t = next_arr;
            end else begin
                // Run until completion or the next arrival, whichever first
                run_len = 32'(job_remain[best]);
                for (int k = 0; k < jobs_loaded; k++) begin
                    if (job_remain[k] != 0 && job_arr[k] > now_t) begin
                        gap = job_arr[k] - now_t;
                        if (gap < run_len)
                            run_len = gap;
                    end
                end
                now_t = now_t + run_len;
                job_remain[best] = BURST_W'(job_remain[best] - run_len);
                if (job_remain[best] == 0) begin
                    done_n++;
                    rec.job_id      = ID_W'(best + 1);
                    rec.turnaround  = TIME_W'(now_t - job_arr[best]);
                    rec.waiting     = TIME_W'(now_t - job_arr[best] - job_burst[best]);
                    rec.last_result = (done_n == jobs_loaded);
                    done_q.push_back(rec);
                end
            end
        end
        jobs_loaded = 0;
    endtask

    always @(posedge i_clk) begin
        t_done_rec want;
        logic [BURST_W-1:0] burst;
        if (i_rst_n) begin
            // Completion record check
            if (i_res.valid && i_res.ready) begin
                rec_cnt++;
                if (done_q.size() == 0) begin
                    report_mismatch("unexpected record, job_id", i_res.job_id, 0);
                end else begin
                    want = done_q.pop_front();
                    if (i_res.job_id !== want.job_id)
                        report_mismatch("job_id", i_res.job_id, want.job_id);
                    if (i_res.turnaround !== want.turnaround)
                        report_mismatch("turnaround", i_res.turnaround, want.turnaround);
                    if (i_res.waiting !== want.waiting)
                        report_mismatch("waiting", i_res.waiting, want.waiting);
                    if (i_res.last_result !== want.last_result)
                        report_mismatch("last_result", i_res.last_result,
                                        want.last_result);
                end
            end
            // Job request load; a zero burst counts as one unit
            if (i_job.valid && i_job.ready) begin
                burst = (i_job.burst_units == 0) ? BURST_W'(1) : i_job.burst_units;
                job_arr[jobs_loaded]    = i_job.arr_tick;
                job_burst[jobs_loaded]  = burst;
                job_prio[jobs_loaded]   = i_job.priority_req;
                job_remain[jobs_loaded] = burst;
                jobs_loaded++;
                if (i_job.last_job || jobs_loaded >= MAX_JOBS)
                    schedule_set();
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= done_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives job sets into the preemptive priority scheduler core: a directed
// part (extremes, zero burst, preemption, tie breaks, full table), then
// random sets of mostly small size with random idling on both channels and
// one long output hold-off. The checker predicts and compares; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import pps_pkg::*;

    localparam int MAX_JOBS     = MAX_PROCESSES_DEF;
    localparam int RAND_ITEMS   = 82;
    localparam int DIRECT_ITEMS = 25;
    localparam int CALM_AFTER   = DIRECT_ITEMS + RAND_ITEMS - 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 20000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   jobs_sent;
    int   stall_cnt = 0;
    bit   calm;
    bit   hold_off_req;

    pps_job_if job_ch ();
    pps_res_if res_ch ();

    preemptive_priority_scheduler_core #(
        .MAX_PROCESSES(MAX_JOBS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_job  (job_ch),
        .o_res  (res_ch)
    );

    pps_checker #(
        .MAX_JOBS(MAX_JOBS)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_ch),
        .i_res       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog: cycles in which neither channel moves a request
    always @(posedge i_clk) begin
        if ((job_ch.valid && job_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
            $display("** preemptive_priority_scheduler_core: FAILED **");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Completion sink: random stall bursts, one long hold-off on request
    initial begin : res_sink
        int run;
        bit held;
        held = 1'b0;
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !held) begin
                held = 1'b1;
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                res_ch.ready = 1'b0;
                run = $urandom_range(1, 8);
                repeat (run - 1) @(negedge i_clk);
            end else begin
                res_ch.ready = 1'b1;
                run = $urandom_range(1, 8);
                repeat (run - 1) @(negedge i_clk);
            end
        end
    end

    // Offer one job request; called and returns at a falling edge
    task automatic push_job(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                            input logic [PRIO_W-1:0] prio, input logic last);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            job_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        job_ch.valid        = 1'b1;
        job_ch.arr_tick     = arr;
        job_ch.burst_units  = burst;
        job_ch.priority_req = prio;
        job_ch.last_job     = last;
        do @(posedge i_clk); while (!job_ch.ready);
        @(negedge i_clk);
        jobs_sent++;
        if (jobs_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    // Random set: tight sets crowd arrivals and priorities, wide ones span
    // the full field ranges
    task automatic push_random_set(input int size, input bit wide);
        logic last;
        for (int k = 0; k < size; k++) begin
            if (size == MAX_JOBS && k == size - 1)
                last = 1'($urandom_range(0, 1));
            else
                last = (k == size - 1);
            if (wide)
                push_job(ARR_W'($urandom()), BURST_W'($urandom()),
                         PRIO_W'($urandom()), last);
            else
                push_job(ARR_W'($urandom_range(0, 31)), BURST_W'($urandom_range(1, 12)),
                         PRIO_W'($urandom_range(0, 3)), last);
        end
    endtask

    initial begin : stimulus
        int size;
        i_rst_n             = 1'b0;
        calm                = 1'b0;
        hold_off_req        = 1'b0;
        jobs_sent           = 0;
        job_ch.valid        = 1'b0;
        job_ch.arr_tick     = '0;
        job_ch.burst_units  = '0;
        job_ch.priority_req = '0;
        job_ch.last_job     = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Single smallest job, then single largest job
        push_job(16'd0, 16'd1, 8'd0, 1'b1);
        push_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        // Zero burst runs as one unit
        push_job(16'd5, 16'd0, 8'd7, 1'b1);
        // Preemption, equal priority and arrival, then an idle gap
        push_job(16'd0, 16'd10, 8'd5, 1'b0);
        push_job(16'd2, 16'd3, 8'd1, 1'b0);
        push_job(16'd2, 16'd2, 8'd1, 1'b0);
        push_job(16'd30, 16'd2, 8'd0, 1'b1);
        // Equal priority: the earlier arrival keeps the processor
        push_job(16'd4, 16'd2, 8'd3, 1'b0);
        push_job(16'd1, 16'd5, 8'd3, 1'b1);
        // Full table with no last marker: later arrivals preempt
        for (int k = 0; k < MAX_JOBS; k++)
            push_job(ARR_W'(k * 3), BURST_W'(2 + (k % 5) * 3),
                     (k == MAX_JOBS - 1) ? 8'd0 : (k == 0 ? 8'hFF : PRIO_W'(MAX_JOBS - k)),
                     1'b0);

        // Long output hold-off while the next sets are offered
        hold_off_req = 1'b1;
        while (jobs_sent < DIRECT_ITEMS + RAND_ITEMS) begin
            case ($urandom_range(0, 19))
                0:        size = MAX_JOBS;
                1, 2, 3:  size = $urandom_range(7, MAX_JOBS - 1);
                default:  size = $urandom_range(1, 6);
            endcase
            push_random_set(size, $urandom_range(0, 3) == 0);
        end
        job_ch.valid = 1'b0;

        // Drain
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("** preemptive_priority_scheduler_core: PASSED **");
        else
            $display("** preemptive_priority_scheduler_core: FAILED **");
        $finish;
    end

endmodule
